[hw/rtl/mstt_pkg.sv]
// Shared types and codes for the timer slot table.
package mstt_pkg;

  localparam int NumSlotsDefault   = 16;
  localparam int PeriodBitsDefault = 16;
  localparam int MaxResults        = 16;

  localparam int ModeW   = 3;
  localparam int PeriodW = 16;
  localparam int SlotW   = 4;
  localparam int StatusW = 3;

  // command codes
  localparam logic [ModeW-1:0] MODE_TICK    = 3'd0;
  localparam logic [ModeW-1:0] MODE_ADD_ONE = 3'd1;
  localparam logic [ModeW-1:0] MODE_ADD_PER = 3'd2;
  localparam logic [ModeW-1:0] MODE_CANCEL  = 3'd3;
  localparam logic [ModeW-1:0] MODE_RELEASE = 3'd4;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK       = 3'd0;
  localparam logic [StatusW-1:0] STATUS_INVALID  = 3'd1;
  localparam logic [StatusW-1:0] STATUS_NOSPACE  = 3'd2;
  localparam logic [StatusW-1:0] STATUS_CANCELED = 3'd3;
  localparam logic [StatusW-1:0] STATUS_EXPIRED  = 3'd4;
  localparam logic [StatusW-1:0] STATUS_RUNNING  = 3'd5;
  localparam logic [StatusW-1:0] STATUS_PERIODIC = 3'd6;

  // per-slot phase; free means the slot holds no timer
  localparam logic [1:0] PH_FREE     = 2'd0;
  localparam logic [1:0] PH_RUNNING  = 2'd1;
  localparam logic [1:0] PH_CANCELED = 2'd2;
  localparam logic [1:0] PH_EXPIRED  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_ADD,
    S_REL
  } fsm_e;

endpackage

[hw/rtl/mstt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mstt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/multi_slot_tick_timer_table.sv]
// Timer slot table: one-shot and periodic count-down timers with tick sweep.
//
// Commands come in on mode_i/period_i/slot_i and are taken when start is
// high and busy is low. Results leave on status_o/slot_number_o/fired_o/
// last_o, each valid for exactly one cycle while result_valid_o is high;
// the receiver cannot stall, so every result must be taken as it appears.
// last_o marks the final result of a command.
//
// How each command is answered, counted from the accept edge:
//   cancel       answers in the next cycle, one result.
//   release      one result, after one slot-memory read.
//   add          the free-slot search looks at one slot per cycle; a bad period
//                answers with no search.
//   tick         one slot read per cycle through the single read port, updates
//                write back in the cycle after the read. Fire results stream out during
//                the sweep, the last one after the closing cycle; none if none fires.
// Unused modes are dropped with no result.
// Reset clears every slot to free at once; period, count and periodic flag
// live in a RAM that needs no clearing.
module multi_slot_tick_timer_table #(
  parameter int NUM_SLOTS   = mstt_pkg::NumSlotsDefault,
  parameter int PERIOD_BITS = mstt_pkg::PeriodBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mstt_pkg::ModeW-1:0]    mode_i,
  input  logic [mstt_pkg::PeriodW-1:0]  period_i,
  input  logic [mstt_pkg::SlotW-1:0]    slot_i,
  output logic                          result_valid_o,
  output logic [mstt_pkg::StatusW-1:0]  status_o,
  output logic [mstt_pkg::SlotW-1:0]    slot_number_o,
  output logic                          fired_o,
  output logic                          last_o
);

  localparam int SlotIdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WordW    = 2 * PERIOD_BITS + 1;
  localparam int CntW     = $clog2(mstt_pkg::MaxResults + 1);
  localparam logic [SlotIdxW-1:0] LastIdx = SlotIdxW'(NUM_SLOTS - 1);

  mstt_pkg::fsm_e state_q, state_d;

  logic [SlotIdxW-1:0]    idx_q, idx_d;
  logic                   issue_q, issue_d;
  logic                   proc_vld_q, proc_vld_d;
  logic [SlotIdxW-1:0]    proc_idx_q, proc_idx_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [SlotIdxW-1:0]    pend_idx_q, pend_idx_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic                   periodic_q, periodic_d;
  logic [SlotIdxW-1:0]    slot_q, slot_d;

  logic                          out_vld_q;
  logic [mstt_pkg::StatusW-1:0]  out_status_q;
  logic [mstt_pkg::SlotW-1:0]    out_slot_q;
  logic                          out_fired_q, out_last_q;

  logic                          emit;
  logic [mstt_pkg::StatusW-1:0]  e_status;
  logic [mstt_pkg::SlotW-1:0]    e_slot;
  logic                          e_fired, e_last;

  // slot phase flops, reset to free
  logic [1:0]          phase_q [NUM_SLOTS];
  logic                ph_we;
  logic [SlotIdxW-1:0] ph_waddr;
  logic [1:0]          ph_wdata;
  logic [SlotIdxW-1:0] ph_raddr;
  logic [1:0]          ph_rd;

  logic                ram_we;
  logic [SlotIdxW-1:0] ram_waddr, ram_raddr;
  logic [WordW-1:0]    ram_wdata, ram_rdata;

  logic [PERIOD_BITS-1:0] rd_rem, rd_per, rem_dec;
  logic                   rd_periodic, fire;

  logic                accept;
  logic [SlotIdxW-1:0] slot_idx;
  logic                slot_in_range, slot_ok, bad_period;
  logic                add_found, add_end, tick_done;

  assign busy   = (state_q != mstt_pkg::S_IDLE);
  assign accept = start && !busy;

  assign slot_idx      = SlotIdxW'(slot_i);
  assign slot_in_range = (32'(slot_i) < NUM_SLOTS);
  assign bad_period    = (period_i == '0) || ((32'(period_i) >> PERIOD_BITS) != '0);

  always_comb begin
    case (state_q)
      mstt_pkg::S_ADD:  ph_raddr = idx_q;
      mstt_pkg::S_TICK: ph_raddr = proc_idx_q;
      mstt_pkg::S_REL:  ph_raddr = slot_q;
      default:          ph_raddr = slot_idx;
    endcase
  end
  assign ph_rd   = phase_q[ph_raddr];
  assign slot_ok = slot_in_range && (ph_rd != mstt_pkg::PH_FREE);

  assign rd_rem      = ram_rdata[PERIOD_BITS-1:0];
  assign rd_per      = ram_rdata[2*PERIOD_BITS-1:PERIOD_BITS];
  assign rd_periodic = ram_rdata[2*PERIOD_BITS];
  assign rem_dec     = rd_rem - PERIOD_BITS'(1);
  assign fire        = proc_vld_q && (ph_rd == mstt_pkg::PH_RUNNING) && (rem_dec == '0);

  assign add_found = (ph_rd == mstt_pkg::PH_FREE);
  assign add_end   = add_found || (idx_q == LastIdx);
  assign tick_done = !issue_q && !proc_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mstt_pkg::S_IDLE: begin
        if (accept) begin
          case (mode_i)
            mstt_pkg::MODE_TICK: state_d = mstt_pkg::S_TICK;
            mstt_pkg::MODE_ADD_ONE, mstt_pkg::MODE_ADD_PER: begin
              if (!bad_period) state_d = mstt_pkg::S_ADD;
            end
            mstt_pkg::MODE_RELEASE: begin
              if (slot_ok) state_d = mstt_pkg::S_REL;
            end
            default: state_d = mstt_pkg::S_IDLE;
          endcase
        end
      end
      mstt_pkg::S_ADD: begin
        if (add_end) state_d = mstt_pkg::S_IDLE;
      end
      mstt_pkg::S_TICK: begin
        if (tick_done) state_d = mstt_pkg::S_IDLE;
      end
      mstt_pkg::S_REL: state_d = mstt_pkg::S_IDLE;
      default: state_d = mstt_pkg::S_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    idx_d      = idx_q;
    issue_d    = issue_q;
    proc_vld_d = proc_vld_q;
    proc_idx_d = proc_idx_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    cnt_d      = cnt_q;
    period_d   = period_q;
    periodic_d = periodic_q;
    slot_d     = slot_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {periodic_q, period_q, period_q};
    ram_raddr = idx_q;

    ph_we    = 1'b0;
    ph_waddr = idx_q;
    ph_wdata = mstt_pkg::PH_FREE;

    emit     = 1'b0;
    e_status = mstt_pkg::STATUS_OK;
    e_slot   = slot_i;
    e_fired  = 1'b0;
    e_last   = 1'b1;

    case (state_q)
      mstt_pkg::S_IDLE: begin
        if (accept) begin
          case (mode_i)
            mstt_pkg::MODE_TICK: begin
              idx_d      = '0;
              issue_d    = 1'b1;
              proc_vld_d = 1'b0;
              pend_vld_d = 1'b0;
              cnt_d      = '0;
            end
            mstt_pkg::MODE_ADD_ONE, mstt_pkg::MODE_ADD_PER: begin
              if (bad_period) begin
                emit     = 1'b1;
                e_status = mstt_pkg::STATUS_INVALID;
                e_slot   = '0;
              end else begin
                period_d   = PERIOD_BITS'(period_i);
                periodic_d = (mode_i == mstt_pkg::MODE_ADD_PER);
                idx_d      = '0;
              end
            end
            mstt_pkg::MODE_CANCEL: begin
              emit = 1'b1;
              if (!slot_ok) begin
                e_status = mstt_pkg::STATUS_INVALID;
              end else if (ph_rd == mstt_pkg::PH_CANCELED) begin
                e_status = mstt_pkg::STATUS_CANCELED;
              end else if (ph_rd == mstt_pkg::PH_EXPIRED) begin
                e_status = mstt_pkg::STATUS_EXPIRED;
              end else begin
                ph_we    = 1'b1;
                ph_waddr = slot_idx;
                ph_wdata = mstt_pkg::PH_CANCELED;
              end
            end
            mstt_pkg::MODE_RELEASE: begin
              if (!slot_ok) begin
                emit     = 1'b1;
                e_status = mstt_pkg::STATUS_INVALID;
              end else begin
                slot_d    = slot_idx;
                ram_raddr = slot_idx;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end

      mstt_pkg::S_ADD: begin
        if (add_found) begin
          ram_we   = 1'b1;
          ph_we    = 1'b1;
          ph_wdata = mstt_pkg::PH_RUNNING;
          emit     = 1'b1;
          e_slot   = mstt_pkg::SlotW'(idx_q);
        end else if (idx_q == LastIdx) begin
          emit     = 1'b1;
          e_status = mstt_pkg::STATUS_NOSPACE;
          e_slot   = '0;
        end else begin
          idx_d = idx_q + SlotIdxW'(1);
        end
      end

      mstt_pkg::S_TICK: begin
        // read side: one slot address per cycle
        if (issue_q) begin
          proc_vld_d = 1'b1;
          proc_idx_d = idx_q;
          if (idx_q == LastIdx) issue_d = 1'b0;
          else                  idx_d   = idx_q + SlotIdxW'(1);
        end else begin
          proc_vld_d = 1'b0;
        end
        // update side: slot read in the previous cycle
        if (proc_vld_q && (ph_rd == mstt_pkg::PH_RUNNING)) begin
          ram_we    = 1'b1;
          ram_waddr = proc_idx_q;
          ram_wdata = {rd_periodic, rd_per, (fire && rd_periodic) ? rd_per : rem_dec};
          if (fire && !rd_periodic) begin
            ph_we    = 1'b1;
            ph_waddr = proc_idx_q;
            ph_wdata = mstt_pkg::PH_EXPIRED;
          end
        end
        // a fire result is held back until the next fire or the end of the sweep so the final one can carry last
        if (fire && (cnt_q < CntW'(mstt_pkg::MaxResults))) begin
          if (pend_vld_q) begin
            emit    = 1'b1;
            e_slot  = mstt_pkg::SlotW'(pend_idx_q);
            e_fired = 1'b1;
            e_last  = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_idx_d = proc_idx_q;
          cnt_d      = cnt_q + CntW'(1);
        end
        if (tick_done && pend_vld_q) begin
          emit       = 1'b1;
          e_slot     = mstt_pkg::SlotW'(pend_idx_q);
          e_fired    = 1'b1;
          pend_vld_d = 1'b0;
        end
      end

      mstt_pkg::S_REL: begin
        emit   = 1'b1;
        e_slot = mstt_pkg::SlotW'(slot_q);
        if (rd_periodic) begin
          e_status = mstt_pkg::STATUS_PERIODIC;
        end else if (ph_rd == mstt_pkg::PH_RUNNING) begin
          e_status = mstt_pkg::STATUS_RUNNING;
        end else begin
          ph_we    = 1'b1;
          ph_waddr = slot_q;
          ph_wdata = mstt_pkg::PH_FREE;
        end
      end

      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mstt_pkg::S_IDLE;
      issue_q    <= 1'b0;
      proc_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        phase_q[i] <= mstt_pkg::PH_FREE;
      end
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      proc_vld_q <= proc_vld_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= emit;
      if (ph_we) begin
        phase_q[ph_waddr] <= ph_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    proc_idx_q   <= proc_idx_d;
    pend_idx_q   <= pend_idx_d;
    period_q     <= period_d;
    periodic_q   <= periodic_d;
    slot_q       <= slot_d;
    out_status_q <= e_status;
    out_slot_q   <= e_slot;
    out_fired_q  <= e_fired;
    out_last_q   <= e_last;
  end

  mstt_ram #(
    .Width(WordW),
    .Depth(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign result_valid_o = out_vld_q;
  assign status_o       = out_status_q;
  assign slot_number_o  = out_slot_q;
  assign fired_o        = out_fired_q;
  assign last_o         = out_last_q;

  // fire results come only out of a tick sweep
  a_fire_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && fired_o |-> $past(state_q == mstt_pkg::S_TICK))
    else $error("fire result outside a tick");

  // command results are single and final
  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !fired_o |-> last_o)
    else $error("command result without last");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && fired_o |-> status_o == mstt_pkg::STATUS_OK)
    else $error("fire result with non-ok status");

  // cancel answers in the next cycle
  a_cancel_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == mstt_pkg::MODE_CANCEL) |=> result_valid_o && !busy)
    else $error("cancel did not answer in one cycle");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(mstt_pkg::MaxResults))
    else $error("fire count past cap");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the timer slot table: command driver, result monitor, predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int NumSlots = mstt_pkg::NumSlotsDefault;

  typedef struct packed {
    logic [mstt_pkg::ModeW-1:0]   mode;
    logic [mstt_pkg::PeriodW-1:0] period;
    logic [mstt_pkg::SlotW-1:0]   slot;
  } timer_cmd_t;

  typedef struct packed {
    logic [mstt_pkg::StatusW-1:0] status;
    logic [mstt_pkg::SlotW-1:0]   slot_no;
    logic                         fired;
    logic                         last;
  } timer_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [mstt_pkg::ModeW-1:0]   mode_i = '0;
  logic [mstt_pkg::PeriodW-1:0] period_i = '0;
  logic [mstt_pkg::SlotW-1:0]   slot_i = '0;
  logic                         result_valid_o;
  logic [mstt_pkg::StatusW-1:0] status_o;
  logic [mstt_pkg::SlotW-1:0]   slot_number_o;
  logic                         fired_o;
  logic                         last_o;

  // predicted table contents
  bit                           slot_held    [NumSlots];
  logic [1:0]                   slot_state   [NumSlots];
  logic [mstt_pkg::PeriodW-1:0] slot_reload  [NumSlots];
  logic [mstt_pkg::PeriodW-1:0] slot_count   [NumSlots];
  bit                           slot_repeats [NumSlots];

  timer_cmd_t    pending_cmds[$];
  timer_result_t awaited_results[$];

  int mismatch_cnt = 0;
  int valid_queued = 0;
  int gap_left = 0;
  int periodic_budget = 4;
  bit gaps_on = 1'b1;
  bit req_taken = 1'b0;

  multi_slot_tick_timer_table #(
    .NUM_SLOTS  (NumSlots),
    .PERIOD_BITS(mstt_pkg::PeriodBitsDefault)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .period_i      (period_i),
    .slot_i        (slot_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .slot_number_o (slot_number_o),
    .fired_o       (fired_o),
    .last_o        (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void note_result(logic [mstt_pkg::StatusW-1:0] status,
                                      logic [mstt_pkg::SlotW-1:0] slot_no,
                                      logic fired, logic last);
    timer_result_t r;
    r.status  = status;
    r.slot_no = slot_no;
    r.fired   = fired;
    r.last    = last;
    awaited_results.push_back(r);
  endfunction

  // Applies one accepted request to the predicted table and queues its results.
  function automatic void advance_timer_table(timer_cmd_t c);
    int            fires;
    int            found;
    timer_result_t r;
    fires = 0;
    found = -1;
    case (c.mode)
      mstt_pkg::MODE_TICK: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_held[i] && slot_state[i] == mstt_pkg::PH_RUNNING) begin
            slot_count[i] = slot_count[i] - 1'b1;
            if (slot_count[i] == '0) begin
              if (slot_repeats[i]) slot_count[i] = slot_reload[i];
              else slot_state[i] = mstt_pkg::PH_EXPIRED;
              if (fires < mstt_pkg::MaxResults) begin
                note_result(mstt_pkg::STATUS_OK, mstt_pkg::SlotW'(i), 1'b1, 1'b0);
                fires++;
              end
            end
          end
        end
        if (fires > 0) begin
          r = awaited_results.pop_back();
          r.last = 1'b1;
          awaited_results.push_back(r);
        end
      end
      mstt_pkg::MODE_ADD_ONE, mstt_pkg::MODE_ADD_PER: begin
        if (c.period == '0) begin
          note_result(mstt_pkg::STATUS_INVALID, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < NumSlots; i++)
            if (!slot_held[i] && found < 0) found = i;
          if (found < 0) begin
            note_result(mstt_pkg::STATUS_NOSPACE, '0, 1'b0, 1'b1);
          end else begin
            slot_held[found]    = 1'b1;
            slot_state[found]   = mstt_pkg::PH_RUNNING;
            slot_reload[found]  = c.period;
            slot_count[found]   = c.period;
            slot_repeats[found] = (c.mode == mstt_pkg::MODE_ADD_PER);
            note_result(mstt_pkg::STATUS_OK, mstt_pkg::SlotW'(found), 1'b0, 1'b1);
          end
        end
      end
      mstt_pkg::MODE_CANCEL: begin
        if (!slot_held[c.slot]) begin
          note_result(mstt_pkg::STATUS_INVALID, c.slot, 1'b0, 1'b1);
        end else if (slot_state[c.slot] == mstt_pkg::PH_CANCELED) begin
          note_result(mstt_pkg::STATUS_CANCELED, c.slot, 1'b0, 1'b1);
        end else if (slot_state[c.slot] == mstt_pkg::PH_EXPIRED) begin
          note_result(mstt_pkg::STATUS_EXPIRED, c.slot, 1'b0, 1'b1);
        end else begin
          slot_state[c.slot] = mstt_pkg::PH_CANCELED;
          note_result(mstt_pkg::STATUS_OK, c.slot, 1'b0, 1'b1);
        end
      end
      mstt_pkg::MODE_RELEASE: begin
        if (!slot_held[c.slot]) begin
          note_result(mstt_pkg::STATUS_INVALID, c.slot, 1'b0, 1'b1);
        end else if (slot_repeats[c.slot]) begin
          note_result(mstt_pkg::STATUS_PERIODIC, c.slot, 1'b0, 1'b1);
        end else if (slot_state[c.slot] == mstt_pkg::PH_RUNNING) begin
          note_result(mstt_pkg::STATUS_RUNNING, c.slot, 1'b0, 1'b1);
        end else begin
          slot_held[c.slot]  = 1'b0;
          slot_state[c.slot] = mstt_pkg::PH_FREE;
          note_result(mstt_pkg::STATUS_OK, c.slot, 1'b0, 1'b1);
        end
      end
      default: ;  // spare modes are dropped
    endcase
  endfunction

  task automatic log_failure(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Driver: a request stays on the bus until the edge that takes it.
  always @(negedge clk_i) begin
    timer_cmd_t nxt;
    if (rst_ni && (!start || req_taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        nxt = pending_cmds.pop_front();
        start    <= 1'b1;
        mode_i   <= nxt.mode;
        period_i <= nxt.period;
        slot_i   <= nxt.slot;
        if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 17);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are checked before the request taken at the same edge is predicted.
  always @(posedge clk_i) begin
    timer_result_t got;
    timer_result_t want;
    timer_cmd_t    c;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.status  = status_o;
        got.slot_no = slot_number_o;
        got.fired   = fired_o;
        got.last    = last_o;
        if (awaited_results.size() == 0) begin
          log_failure($sformatf("unexpected result: status %0d slot %0d fired %b last %b",
                                got.status, got.slot_no, got.fired, got.last));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.slot_no !== want.slot_no ||
              got.fired !== want.fired || got.last !== want.last)
            log_failure($sformatf({"result mismatch: expected status %0d slot %0d fired %b ",
                                   "last %b, got status %0d slot %0d fired %b last %b"},
                                  want.status, want.slot_no, want.fired, want.last,
                                  got.status, got.slot_no, got.fired, got.last));
        end
      end
      req_taken = start && !busy;
      if (req_taken) begin
        c.mode   = mode_i;
        c.period = period_i;
        c.slot   = slot_i;
        advance_timer_table(c);
      end
    end
  end

  task automatic queue_cmd(logic [mstt_pkg::ModeW-1:0] mode,
                           logic [mstt_pkg::PeriodW-1:0] period,
                           logic [mstt_pkg::SlotW-1:0] slot);
    timer_cmd_t c;
    c.mode   = mode;
    c.period = period;
    c.slot   = slot;
    pending_cmds.push_back(c);
    if (mode <= mstt_pkg::MODE_RELEASE) valid_queued++;
  endtask

  // Sender holds off until every request is taken and every result is back.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [mstt_pkg::PeriodW-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mstt_pkg::PeriodW'($urandom_range(0, 65535));
      2:       return mstt_pkg::PeriodW'(1) << $urandom_range(0, mstt_pkg::PeriodW - 1);
      default: return mstt_pkg::PeriodW'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [mstt_pkg::SlotW-1:0] pick_held_slot();
    int held[$];
    for (int i = 0; i < NumSlots; i++)
      if (slot_held[i]) held.push_back(i);
    if (held.size() == 0 || $urandom_range(0, 4) == 0)
      return mstt_pkg::SlotW'($urandom_range(0, 15));
    return mstt_pkg::SlotW'(held[$urandom_range(0, held.size() - 1)]);
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 0; i < NumSlots; i++)
      if (!slot_held[i]) n++;
    return n;
  endfunction

  function automatic logic [mstt_pkg::PeriodW-1:0] any_period();
    return mstt_pkg::PeriodW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [mstt_pkg::SlotW-1:0] any_slot();
    return mstt_pkg::SlotW'($urandom_range(0, 15));
  endfunction

  // Frees one-shot slots; only call once idle, since it reads the predicted table.
  task automatic tidy_table(bit keep_short);
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_held[i] && !slot_repeats[i]) begin
        if (slot_state[i] != mstt_pkg::PH_RUNNING) begin
          queue_cmd(mstt_pkg::MODE_RELEASE, any_period(), mstt_pkg::SlotW'(i));
        end else if (!keep_short || slot_count[i] > 6) begin
          queue_cmd(mstt_pkg::MODE_CANCEL, any_period(), mstt_pkg::SlotW'(i));
          queue_cmd(mstt_pkg::MODE_RELEASE, any_period(), mstt_pkg::SlotW'(i));
        end
      end
    end
  endtask

  // Fill every free slot with a one-tick timer, overflow the table, then fire them together.
  task automatic fill_and_fire();
    int room;
    wait_idle();
    tidy_table(1'b0);
    wait_idle();
    room = free_slots();
    repeat (room) queue_cmd(mstt_pkg::MODE_ADD_ONE, 16'd1, any_slot());
    queue_cmd(mstt_pkg::MODE_ADD_ONE, 16'hFFFF, '0);
    queue_cmd(mstt_pkg::MODE_ADD_PER, 16'd1, '1);
    queue_cmd(mstt_pkg::MODE_TICK, any_period(), any_slot());
    queue_cmd(mstt_pkg::MODE_TICK, any_period(), any_slot());
    wait_idle();
    tidy_table(1'b0);
  endtask

  task automatic mixed_burst();
    int steps;
    int pick;
    bit periodic;
    steps = $urandom_range(6, 14);
    repeat (steps) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        queue_cmd(mstt_pkg::MODE_TICK, any_period(), any_slot());
      end else if (pick < 11) begin
        // periodic slots can never be freed, so they are rationed
        periodic = periodic_budget > 0 && $urandom_range(0, 4) == 0;
        if (periodic) periodic_budget--;
        queue_cmd(periodic ? mstt_pkg::MODE_ADD_PER : mstt_pkg::MODE_ADD_ONE, pick_period(),
                  any_slot());
      end else if (pick < 14) begin
        queue_cmd(mstt_pkg::MODE_CANCEL, any_period(), pick_held_slot());
      end else if (pick < 18) begin
        queue_cmd(mstt_pkg::MODE_RELEASE, any_period(), pick_held_slot());
      end else begin
        queue_cmd(mstt_pkg::MODE_RELEASE + mstt_pkg::ModeW'($urandom_range(0, 3)),
                  any_period(), any_slot());
      end
    end
    wait_idle();
    if ($urandom_range(0, 2) != 0) tidy_table(1'b1);
  endtask

  initial begin
    int rand_base;
    int first_free;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_cmd(mstt_pkg::MODE_TICK, '0, '0);            // empty table, nothing fires
    queue_cmd(mstt_pkg::MODE_ADD_ONE, '0, '0);         // zero period
    queue_cmd(mstt_pkg::MODE_ADD_PER, '0, '1);
    queue_cmd(mstt_pkg::MODE_ADD_ONE, 16'd1, '0);
    queue_cmd(mstt_pkg::MODE_ADD_PER, 16'd1, '0);      // fires on every tick from here on
    queue_cmd(mstt_pkg::MODE_ADD_ONE, 16'hFFFF, '0);
    queue_cmd(mstt_pkg::MODE_ADD_ONE, 16'd2, '0);
    queue_cmd(mstt_pkg::MODE_CANCEL, '0, 4'd15);       // empty slot
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, 4'd15);
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, 4'd0);       // one-shot still running
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, 4'd1);       // periodic
    queue_cmd(mstt_pkg::MODE_TICK, '0, '0);
    queue_cmd(mstt_pkg::MODE_CANCEL, '0, 4'd0);        // already expired
    queue_cmd(mstt_pkg::MODE_CANCEL, '0, 4'd2);
    queue_cmd(mstt_pkg::MODE_CANCEL, '0, 4'd2);        // already canceled
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, 4'd2);
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, 4'd2);       // freed just before
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, 4'd0);
    queue_cmd(mstt_pkg::MODE_RELEASE + 3'd1, '1, '1);  // spare modes
    queue_cmd(mstt_pkg::MODE_RELEASE + 3'd2, '1, '1);
    queue_cmd(mstt_pkg::MODE_RELEASE + 3'd3, '1, '1);
    queue_cmd(mstt_pkg::MODE_TICK, '1, '1);
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, 4'd3);
    rand_base = valid_queued;

    fill_and_fire();

    // a canceled periodic slot still refuses release
    wait_idle();
    first_free = -1;
    for (int i = 0; i < NumSlots; i++)
      if (!slot_held[i] && first_free < 0) first_free = i;
    queue_cmd(mstt_pkg::MODE_ADD_PER, mstt_pkg::PeriodW'($urandom_range(1, 65535)), '0);
    queue_cmd(mstt_pkg::MODE_CANCEL, '0, mstt_pkg::SlotW'(first_free));
    queue_cmd(mstt_pkg::MODE_RELEASE, '0, mstt_pkg::SlotW'(first_free));
    queue_cmd(mstt_pkg::MODE_CANCEL, '0, mstt_pkg::SlotW'(first_free));

    while (valid_queued - rand_base < 40) mixed_burst();

    gaps_on = 1'b0;
    wait_idle();
    gap_left = 0;
    mixed_burst();
    fill_and_fire();

    wait_idle();
    repeat (2 * NumSlots + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && awaited_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mstt_pkg.sv
hw/rtl/mstt_ram.sv
hw/rtl/multi_slot_tick_timer_table.sv
tb/sv/testbench.sv
